FILE: rtl/abfd_pkg.sv
// abfd_pkg: widths, region and register codes, carried item type and
// fixed-point helpers for the absorbing boundary field damper.
// No dependencies.
`timescale 1ns / 1ps

package abfd_pkg;

  localparam int CELL_W      = 16;
  localparam int FIELD_W     = 32;
  localparam int STRENGTH_W  = 5;
  localparam int KIND_W      = 2;
  localparam int RATIO_BITS  = 24;
  localparam int LAMBDA_BITS = 29;
  localparam int WEIGHT_W    = 17;
  localparam int DIV_STAGES  = RATIO_BITS / 2;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;

  localparam logic [KIND_W-1:0] KIND_UNTOUCHED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BLENDED   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REPLACED  = 2'd2;

  localparam logic [1:0] REG_SIDE     = 2'd0;
  localparam logic [1:0] REG_START    = 2'd1;
  localparam logic [1:0] REG_END      = 2'd2;
  localparam logic [1:0] REG_STRENGTH = 2'd3;

  localparam logic                         SIDE_RESET     = 1'b0;
  localparam logic signed [CELL_W-1:0]     START_RESET    = 16'sd0;
  localparam logic signed [CELL_W-1:0]     END_RESET      = 16'sd16;
  localparam logic [STRENGTH_W-1:0]        STRENGTH_RESET = 5'd10;

  localparam logic [63:0] Q62_ONE = 64'h4000_0000_0000_0000;

  typedef struct packed {
    logic signed [FIELD_W-1:0] live_value;
    logic signed [FIELD_W-1:0] ref_value;
    logic [KIND_W-1:0]         kind;
  } carry_t;

  // Q2.62 product, floored
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[125:62];
  endfunction

  // x / k for the Taylor series terms, k in 1..24
  function automatic logic [63:0] series_div(input logic [63:0] x, input logic [4:0] k);
    logic [63:0] q;
    case (k)
      5'd2:  q = x / 64'd2;
      5'd3:  q = x / 64'd3;
      5'd4:  q = x / 64'd4;
      5'd5:  q = x / 64'd5;
      5'd6:  q = x / 64'd6;
      5'd7:  q = x / 64'd7;
      5'd8:  q = x / 64'd8;
      5'd9:  q = x / 64'd9;
      5'd10: q = x / 64'd10;
      5'd11: q = x / 64'd11;
      5'd12: q = x / 64'd12;
      5'd13: q = x / 64'd13;
      5'd14: q = x / 64'd14;
      5'd15: q = x / 64'd15;
      5'd16: q = x / 64'd16;
      5'd17: q = x / 64'd17;
      5'd18: q = x / 64'd18;
      5'd19: q = x / 64'd19;
      5'd20: q = x / 64'd20;
      5'd21: q = x / 64'd21;
      5'd22: q = x / 64'd22;
      5'd23: q = x / 64'd23;
      5'd24: q = x / 64'd24;
      default: q = x;
    endcase
    return q;
  endfunction

  // one restoring division step: {quotient bit, new remainder}
  function automatic logic [CELL_W:0] div_step(input logic [CELL_W-1:0] rem,
                                               input logic [CELL_W-1:0] divisor);
    logic [CELL_W:0] twice;
    logic [CELL_W:0] diff;
    logic [CELL_W:0] res;
    twice = {rem, 1'b0};
    diff  = twice - {1'b0, divisor};
    if (twice >= {1'b0, divisor}) begin
      res = {1'b1, diff[CELL_W-1:0]};
    end else begin
      res = {1'b0, twice[CELL_W-1:0]};
    end
    return res;
  endfunction

endpackage

FILE: rtl/abfd_sample_if.sv
// abfd_sample_if: input item channel (valid/ready plus cell payload).
// Depends on abfd_pkg.
`timescale 1ns / 1ps

interface abfd_sample_if import abfd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [CELL_W-1:0]   cell_coord;
  logic signed [FIELD_W-1:0]  live_value;
  logic signed [FIELD_W-1:0]  reference_value;

  modport source (output valid, cell_coord, live_value, reference_value, input ready);
  modport sink   (input valid, cell_coord, live_value, reference_value, output ready);
endinterface

FILE: rtl/abfd_result_if.sv
// abfd_result_if: result item channel (valid/ready plus updated value).
// Depends on abfd_pkg.
`timescale 1ns / 1ps

interface abfd_result_if import abfd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [FIELD_W-1:0]  new_value;
  logic [KIND_W-1:0]          region_kind;

  modport source (output valid, new_value, region_kind, input ready);
  modport sink   (input valid, new_value, region_kind, output ready);
endinterface

FILE: rtl/abfd_weight_rom.sv
// abfd_weight_rom: e^-lambda weight table, Q1.16, registered read.
// Contents built at elaboration; depends on abfd_pkg.
`timescale 1ns / 1ps

module abfd_weight_rom import abfd_pkg::*; #(
  parameter int EXP_TABLE_BITS = 10
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [EXP_TABLE_BITS-1:0] addr,
  output logic [WEIGHT_W-1:0]       weight
);

  localparam int TABLE_SIZE = 1 << EXP_TABLE_BITS;
  localparam int SHIFT      = EXP_TABLE_BITS - 5;

  typedef logic [WEIGHT_W-1:0] wtab_t [TABLE_SIZE];

  // per-entry ratio e^(-32/TABLE_SIZE) from a 24-term series, then repeated products
  function automatic wtab_t build_wtab();
    wtab_t       tab;
    logic [63:0] term;
    logic [63:0] ratio;
    logic [63:0] p;
    logic [63:0] rounded;
    term  = Q62_ONE;
    ratio = Q62_ONE;
    for (int k = 1; k <= 24; k++) begin
      term = series_div(term >> SHIFT, 5'(k));
      if (k[0]) begin
        ratio = ratio - term;
      end else begin
        ratio = ratio + term;
      end
    end
    p = Q62_ONE;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      rounded = (p + (64'd1 << 45)) >> 46;
      tab[i]  = rounded[WEIGHT_W-1:0];
      p       = mul_q62(p, ratio);
    end
    return tab;
  endfunction

  localparam wtab_t WEIGHT_TAB = build_wtab();

  always_ff @(posedge clk) begin
    if (en) begin
      weight <= WEIGHT_TAB[addr];
    end
  end

endmodule

FILE: rtl/absorbing_boundary_field_damper.sv
// Absorbing boundary field damper: cubic-profile layer blend of a field sample.
// Pipeline: 19 register stages (1 classify stage, 12 divider stages at two quotient bits
// each, 6 multiply/table/blend stages). Throughput: one item per cycle while the output
// is taken; a stage holds only while the output stalls and it and all after it are full.
// Reset (rst, sync, active high) clears the stage valid bits and loads register defaults.
`timescale 1ns / 1ps

module absorbing_boundary_field_damper import abfd_pkg::*; #(
  parameter int EXP_TABLE_BITS = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  abfd_sample_if.sink       sample,
  abfd_result_if.source     result
);

  // stage map
  localparam int S_SQ   = DIV_STAGES + 1;
  localparam int S_CUBE = DIV_STAGES + 2;
  localparam int S_IDX  = DIV_STAGES + 3;
  localparam int S_ROM  = DIV_STAGES + 4;
  localparam int S_PROD = DIV_STAGES + 5;
  localparam int S_OUT  = DIV_STAGES + 6;
  localparam int NS     = DIV_STAGES + 7;

  localparam logic signed [50:0] ROUND_HALF = 51'sd32768;

  // ---------------------------------------------------------------------------
  // Configuration registers (every stage reads them directly, so the user must write
  // them only while idle; the block itself does not enforce this)
  // ---------------------------------------------------------------------------
  logic                         layer_side;
  logic signed [CELL_W-1:0]     damp_start;
  logic signed [CELL_W-1:0]     damp_end;
  logic [STRENGTH_W-1:0]        damp_strength;
  logic                         cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      layer_side    <= SIDE_RESET;
      damp_start    <= START_RESET;
      damp_end      <= END_RESET;
      damp_strength <= STRENGTH_RESET;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_SIDE:     layer_side    <= pwdata[0];
        REG_START:    damp_start    <= pwdata[CELL_W-1:0];
        REG_END:      damp_end      <= pwdata[CELL_W-1:0];
        REG_STRENGTH: damp_strength <= pwdata[STRENGTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SIDE:     prdata = {{(DATA_W-1){1'b0}}, layer_side};
      REG_START:    prdata = {{(DATA_W-CELL_W){damp_start[CELL_W-1]}}, damp_start};
      REG_END:      prdata = {{(DATA_W-CELL_W){damp_end[CELL_W-1]}}, damp_end};
      REG_STRENGTH: prdata = {{(DATA_W-STRENGTH_W){1'b0}}, damp_strength};
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stage flow control: a stage loads when it is empty or something after it
  // moves, i.e. the output is taken or there is a bubble further down.
  // ---------------------------------------------------------------------------
  logic [NS-1:0] v_q;
  logic [NS-1:0] rdy;

  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = result.ready | ~(&v_q[NS-1:k]);
  end

  assign sample.ready = rdy[0];
  assign result.valid = v_q[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= sample.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  carry_t carry_q [NS];

  for (genvar k = 1; k < NS; k++) begin : g_carry
    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        carry_q[k] <= carry_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: region classification, distance into the layer
  // ---------------------------------------------------------------------------
  logic                      replaced;
  logic                      blended;
  logic signed [CELL_W:0]    dist_wide;
  logic signed [CELL_W:0]    span_wide;
  logic [CELL_W-1:0]         span;
  logic [KIND_W-1:0]         kind;
  logic [CELL_W-1:0]         rem_q [DIV_STAGES+1];
  logic [RATIO_BITS-1:0]     quo_q [DIV_STAGES+1];

  always_comb begin
    if (layer_side) begin
      replaced  = sample.cell_coord >= damp_start;
      blended   = !replaced && (sample.cell_coord > damp_end);
      dist_wide = 17'(sample.cell_coord) - 17'(damp_end);
      span_wide = 17'(damp_start) - 17'(damp_end);
    end else begin
      replaced  = sample.cell_coord <= damp_start;
      blended   = !replaced && (sample.cell_coord < damp_end);
      dist_wide = 17'(damp_end) - 17'(sample.cell_coord);
      span_wide = 17'(damp_end) - 17'(damp_start);
    end
    if (replaced) begin
      kind = KIND_REPLACED;
    end else if (blended) begin
      kind = KIND_BLENDED;
    end else begin
      kind = KIND_UNTOUCHED;
    end
  end

  // span is a function of config only; inside the layer 0 < dist < span <= 65535
  assign span = span_wide[CELL_W-1:0];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      carry_q[0].live_value <= sample.live_value;
      carry_q[0].ref_value  <= sample.reference_value;
      carry_q[0].kind       <= kind;
      rem_q[0]              <= dist_wide[CELL_W-1:0];
      quo_q[0]              <= '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 1..12: restoring divider, ratio = dist * 2^24 / span, two bits a stage
  // ---------------------------------------------------------------------------
  for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_div
    logic [CELL_W:0] step_hi;
    logic [CELL_W:0] step_lo;

    assign step_hi = div_step(rem_q[j-1], span);
    assign step_lo = div_step(step_hi[CELL_W-1:0], span);

    always_ff @(posedge clk) begin
      if (rdy[j]) begin
        rem_q[j] <= step_lo[CELL_W-1:0];
        quo_q[j] <= {quo_q[j-1][RATIO_BITS-3:0], step_hi[CELL_W], step_lo[CELL_W]};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Cube of the ratio, lambda and table index
  // ---------------------------------------------------------------------------
  logic [2*RATIO_BITS-1:0]   sq_full;
  logic [2*RATIO_BITS-1:0]   cube_full;
  logic [RATIO_BITS-1:0]     r_sq_q;
  logic [RATIO_BITS-1:0]     r2_q;
  logic [RATIO_BITS-1:0]     r3_q;
  logic [LAMBDA_BITS-1:0]    lambda;
  logic [EXP_TABLE_BITS-1:0] idx_q;
  logic [WEIGHT_W-1:0]       weight;

  assign sq_full = (2*RATIO_BITS)'(quo_q[DIV_STAGES]) * (2*RATIO_BITS)'(quo_q[DIV_STAGES]);

  always_ff @(posedge clk) begin
    if (rdy[S_SQ]) begin
      r2_q   <= sq_full[2*RATIO_BITS-1:RATIO_BITS];
      r_sq_q <= quo_q[DIV_STAGES];
    end
  end

  assign cube_full = (2*RATIO_BITS)'(r2_q) * (2*RATIO_BITS)'(r_sq_q);

  always_ff @(posedge clk) begin
    if (rdy[S_CUBE]) begin
      r3_q <= cube_full[2*RATIO_BITS-1:RATIO_BITS];
    end
  end

  // lambda in Q5.24 stays below 2^29, so the top bits are the index
  assign lambda = LAMBDA_BITS'(damp_strength) * LAMBDA_BITS'(r3_q);

  always_ff @(posedge clk) begin
    if (rdy[S_IDX]) begin
      idx_q <= lambda[LAMBDA_BITS-1 -: EXP_TABLE_BITS];
    end
  end

  abfd_weight_rom #(
    .EXP_TABLE_BITS (EXP_TABLE_BITS)
  ) u_weight_rom (
    .clk    (clk),
    .en     (rdy[S_ROM]),
    .addr   (idx_q),
    .weight (weight)
  );

  // ---------------------------------------------------------------------------
  // Blend: w*live + (1-w)*ref, rounded, floored, saturated
  // ---------------------------------------------------------------------------
  logic [WEIGHT_W-1:0]       weight_c;
  logic signed [49:0]        p_live_q;
  logic signed [49:0]        p_ref_q;
  logic signed [50:0]        acc;
  logic signed [34:0]        scaled;
  logic signed [FIELD_W-1:0] blend_sat;
  logic signed [FIELD_W-1:0] new_value_q;
  logic [KIND_W-1:0]         region_kind_q;

  assign weight_c = WEIGHT_ONE - weight;

  always_ff @(posedge clk) begin
    if (rdy[S_PROD]) begin
      p_live_q <= $signed({{(50-WEIGHT_W){1'b0}}, weight})
                  * 50'(carry_q[S_ROM].live_value);
      p_ref_q  <= $signed({{(50-WEIGHT_W){1'b0}}, weight_c})
                  * 50'(carry_q[S_ROM].ref_value);
    end
  end

  always_comb begin
    acc    = {p_live_q[49], p_live_q} + {p_ref_q[49], p_ref_q} + ROUND_HALF;
    scaled = acc[50:16];
    if (!scaled[34] && (scaled[33:31] != 3'b000)) begin
      blend_sat = {1'b0, {(FIELD_W-1){1'b1}}};
    end else if (scaled[34] && (scaled[33:31] != 3'b111)) begin
      blend_sat = {1'b1, {(FIELD_W-1){1'b0}}};
    end else begin
      blend_sat = scaled[FIELD_W-1:0];
    end
  end

  // output register; region chosen at the last stage
  always_ff @(posedge clk) begin
    if (rdy[S_OUT]) begin
      region_kind_q <= carry_q[S_PROD].kind;
      case (carry_q[S_PROD].kind)
        KIND_REPLACED: new_value_q <= carry_q[S_PROD].ref_value;
        KIND_BLENDED:  new_value_q <= blend_sat;
        default:       new_value_q <= carry_q[S_PROD].live_value;
      endcase
    end
  end

  assign result.new_value   = new_value_q;
  assign result.region_kind = region_kind_q;

endmodule
